>>> design/ced_pkg.sv
// Shared types and constants for the escape sequence decoder.
// Used by ced_front, ced_fifo, ced_back and the top level; no dependencies.
package ced_pkg;

  // Status codes reported on the last result of a string
  localparam logic [1:0] StatusOk     = 2'd0;
  localparam logic [1:0] StatusBadEsc = 2'd1;
  localparam logic [1:0] StatusNoHex  = 2'd2;

  // Depth of the queue between classifier and output stage
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned CntW      = $clog2(FifoDepth + 1);

  // One queue entry: the results caused by one accepted request.
  // The second result, when present, is always a plain data byte.
  typedef struct packed {
    logic       two;
    logic [7:0] data0;
    logic       has0;
    logic       last0;
    logic [1:0] status0;
    logic [7:0] data1;
  } entry_t;

endpackage

>>> design/ced_front.sv
// Front end: accepts requests, tracks escape parsing state and classifies
// each byte into zero, one or two results. Depends on ced_pkg.
module ced_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      in_byte_i,
  input  logic            end_of_string_i,
  output logic            push_o,
  output ced_pkg::entry_t entry_o
);

  typedef enum logic [2:0] {
    ModeIdle    = 3'd0,
    ModeEsc     = 3'd1,
    ModeOct1    = 3'd2,
    ModeOct2    = 3'd3,
    ModeHexWait = 3'd4,
    ModeHex1    = 3'd5
  } mode_e;

  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChQuote     = 8'h27;
  localparam logic [7:0] ChDquote    = 8'h22;
  localparam logic [7:0] ChQuestion  = 8'h3F;
  localparam logic [7:0] ChA         = 8'h61;
  localparam logic [7:0] ChB         = 8'h62;
  localparam logic [7:0] ChF         = 8'h66;
  localparam logic [7:0] ChN         = 8'h6E;
  localparam logic [7:0] ChR         = 8'h72;
  localparam logic [7:0] ChT         = 8'h74;
  localparam logic [7:0] ChV         = 8'h76;
  localparam logic [7:0] ChX         = 8'h78;

  localparam logic [7:0] CodeBel = 8'h07;
  localparam logic [7:0] CodeBs  = 8'h08;
  localparam logic [7:0] CodeFf  = 8'h0C;
  localparam logic [7:0] CodeLf  = 8'h0A;
  localparam logic [7:0] CodeCr  = 8'h0D;
  localparam logic [7:0] CodeHt  = 8'h09;
  localparam logic [7:0] CodeVt  = 8'h0B;

  mode_e      mode_q, mode_d;
  logic [8:0] acc_q, acc_d;
  logic [1:0] err_q, err_d;

  logic       is_oct;
  logic       is_hex;
  logic [3:0] hex_val;
  logic [8:0] oct_next;
  logic [8:0] hex_next;
  logic       flush;

  assign is_oct   = (in_byte_i >= 8'h30) && (in_byte_i <= 8'h37);
  assign oct_next = {acc_q[5:0], in_byte_i[2:0]};
  assign hex_next = {acc_q[4:0], hex_val};

  always_comb begin
    is_hex  = 1'b1;
    hex_val = 4'd0;
    if ((in_byte_i >= 8'h30) && (in_byte_i <= 8'h39)) begin
      hex_val = in_byte_i[3:0];
    end else if (((in_byte_i >= 8'h61) && (in_byte_i <= 8'h66)) ||
                 ((in_byte_i >= 8'h41) && (in_byte_i <= 8'h46))) begin
      // low three bits of a..f / A..F are 1..6
      hex_val = 4'd9 + {1'b0, in_byte_i[2:0]};
    end else begin
      is_hex = 1'b0;
    end
  end

  always_comb begin
    mode_d  = mode_q;
    acc_d   = acc_q;
    err_d   = err_q;
    push_o  = 1'b0;
    entry_o = '0;
    flush   = 1'b0;
    if (accept_i) begin
      if (end_of_string_i) begin
        push_o        = 1'b1;
        entry_o.last0 = 1'b1;
        if (err_q != ced_pkg::StatusOk) begin
          entry_o.status0 = err_q;
        end else begin
          case (mode_q)
            ModeOct1, ModeOct2, ModeHex1: begin
              entry_o.has0  = 1'b1;
              entry_o.data0 = acc_q[7:0];
            end
            ModeEsc:     entry_o.status0 = ced_pkg::StatusBadEsc;
            ModeHexWait: entry_o.status0 = ced_pkg::StatusNoHex;
            default:     entry_o.status0 = ced_pkg::StatusOk;
          endcase
        end
        mode_d = ModeIdle;
        acc_d  = '0;
        err_d  = ced_pkg::StatusOk;
      end else if (err_q == ced_pkg::StatusOk) begin
        case (mode_q)
          ModeEsc: begin
            mode_d = ModeIdle;
            if (is_oct) begin
              acc_d  = {6'd0, in_byte_i[2:0]};
              mode_d = ModeOct1;
            end else begin
              entry_o.has0 = 1'b1;
              push_o       = 1'b1;
              case (in_byte_i)
                ChQuote, ChDquote, ChQuestion, ChBackslash: entry_o.data0 = in_byte_i;
                ChA: entry_o.data0 = CodeBel;
                ChB: entry_o.data0 = CodeBs;
                ChF: entry_o.data0 = CodeFf;
                ChN: entry_o.data0 = CodeLf;
                ChR: entry_o.data0 = CodeCr;
                ChT: entry_o.data0 = CodeHt;
                ChV: entry_o.data0 = CodeVt;
                ChX: begin
                  push_o       = 1'b0;
                  entry_o.has0 = 1'b0;
                  mode_d       = ModeHexWait;
                end
                default: begin
                  push_o       = 1'b0;
                  entry_o.has0 = 1'b0;
                  err_d        = ced_pkg::StatusBadEsc;
                end
              endcase
            end
          end
          ModeOct1, ModeOct2: begin
            if (is_oct) begin
              if (mode_q == ModeOct1) begin
                acc_d  = oct_next;
                mode_d = ModeOct2;
              end else begin
                push_o        = 1'b1;
                entry_o.has0  = 1'b1;
                entry_o.data0 = oct_next[7:0];
                acc_d         = '0;
                mode_d        = ModeIdle;
              end
            end else begin
              flush = 1'b1;
            end
          end
          ModeHexWait: begin
            if (is_hex) begin
              acc_d  = {5'd0, hex_val};
              mode_d = ModeHex1;
            end else begin
              err_d  = ced_pkg::StatusNoHex;
              mode_d = ModeIdle;
            end
          end
          ModeHex1: begin
            if (is_hex) begin
              push_o        = 1'b1;
              entry_o.has0  = 1'b1;
              entry_o.data0 = hex_next[7:0];
              acc_d         = '0;
              mode_d        = ModeIdle;
            end else begin
              flush = 1'b1;
            end
          end
          default: begin
            mode_d = ModeIdle;
            if (in_byte_i == ChBackslash) begin
              mode_d = ModeEsc;
            end else begin
              push_o        = 1'b1;
              entry_o.has0  = 1'b1;
              entry_o.data0 = in_byte_i;
            end
          end
        endcase
        // pending value ended by a byte that cannot extend it
        if (flush) begin
          push_o        = 1'b1;
          entry_o.has0  = 1'b1;
          entry_o.data0 = acc_q[7:0];
          acc_d         = '0;
          mode_d        = ModeIdle;
          if (in_byte_i == ChBackslash) begin
            mode_d = ModeEsc;
          end else begin
            entry_o.two   = 1'b1;
            entry_o.data1 = in_byte_i;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle;
      acc_q  <= '0;
      err_q  <= ced_pkg::StatusOk;
    end else begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
      err_q  <= err_d;
    end
  end

endmodule

>>> design/ced_fifo.sv
// Short queue of classified entries between front end and output stage.
// Depends on ced_pkg for the entry type and depth.
module ced_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ced_pkg::entry_t entry_i,
  input  logic            pop_i,
  output ced_pkg::entry_t head_o,
  output logic            empty_o,
  output logic            full_o
);

  ced_pkg::entry_t                 slots_q [ced_pkg::FifoDepth];
  logic [ced_pkg::PtrW-1:0]        wr_ptr_q, rd_ptr_q;
  logic [ced_pkg::CntW-1:0]        count_q;
  logic                            do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == ced_pkg::CntW'(ced_pkg::FifoDepth));
  assign head_o  = slots_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

>>> design/ced_back.sv
// Output stage: pops queue entries and presents their one or two results
// in a registered output with valid/ready. Depends on ced_pkg.
module ced_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ced_pkg::entry_t head_i,
  input  logic            empty_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            has_data_o,
  output logic            last_o,
  output logic [1:0]      status_o
);

  logic       valid_q;
  logic [7:0] data_q;
  logic       has_q;
  logic       last_q;
  logic [1:0] status_q;
  logic       second_q;
  logic [7:0] second_data_q;
  logic       load;

  // the output register is free when empty or being taken this cycle
  assign load  = !valid_q || out_ready_i;
  assign pop_o = load && !second_q && !empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      second_q <= 1'b0;
    end else if (load) begin
      if (second_q) begin
        valid_q  <= 1'b1;
        second_q <= 1'b0;
      end else if (!empty_i) begin
        valid_q  <= 1'b1;
        second_q <= head_i.two;
      end else begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (second_q) begin
        data_q   <= second_data_q;
        has_q    <= 1'b1;
        last_q   <= 1'b0;
        status_q <= ced_pkg::StatusOk;
      end else if (!empty_i) begin
        data_q        <= head_i.data0;
        has_q         <= head_i.has0;
        last_q        <= head_i.last0;
        status_q      <= head_i.status0;
        second_data_q <= head_i.data1;
      end
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = data_q;
  assign has_data_o  = has_q;
  assign last_o      = last_q;
  assign status_o    = status_q;

endmodule

>>> design/c_escape_sequence_decoder_top.sv
// Escape sequence decoder: one byte per request, decoded bytes out.
// A result passes a queue slot, then the output register, before it appears.
// Throughput: one byte per cycle while the queue has room; a byte ending a
// pending value that also passes through yields two results, sent in turn.
// The four-entry queue between front end and output stage absorbs stalls.
// Reset (asynchronous, active low) returns the parser to idle, clears error.
module c_escape_sequence_decoder_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_string_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       has_data_o,
  output logic       last_o,
  output logic [1:0] status_o
);

  logic            accept;
  logic            push;
  logic            pop;
  logic            empty;
  logic            full;
  ced_pkg::entry_t entry;
  ced_pkg::entry_t head;

  assign in_ready_o = !full;
  assign accept     = in_valid_i && !full;

  ced_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .in_byte_i       (in_byte_i),
    .end_of_string_i (end_of_string_i),
    .push_o          (push),
    .entry_o         (entry)
  );

  ced_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (empty),
    .full_o  (full)
  );

  ced_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .has_data_o  (has_data_o),
    .last_o      (last_o),
    .status_o    (status_o)
  );

endmodule
